### hdl/gmps_pkg.sv
// ----------------------------------------------------------------------------
// gmps_pkg
// Shared types and constants for the grid minimum path sum block.
// ----------------------------------------------------------------------------
package gmps_pkg;

  // Largest grid the row buffer and position counters are sized for.
  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLUMNS = 256;

  // Field widths fixed by the interface.
  localparam int CELL_W     = 8;
  localparam int COST_W     = 17;
  localparam int DIM_W      = 9;
  localparam int START_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Position counter widths and widths of the clamped dimensions.
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
  localparam int COLS_W  = $clog2(MAX_COLUMNS + 1);

  // Depth of the queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_START_ROW    = 2'd2,
    CFG_START_COLUMN = 2'd3
  } cfg_reg_t;

  // One classified cell, as handed from the front to the back.
  typedef struct packed {
    logic [CELL_W-1:0] cost;
    logic [COL_W-1:0]  col;
    logic              active;     // Cell lies inside the start-to-goal rectangle.
    logic              has_up;
    logic              has_left;
    logic              last;       // Bottom-right cell of the grid.
    logic              outside;    // Start cell lies outside the grid.
  } cell_op_t;

  // Status of the queue as seen by its two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

### hdl/gmps_if.sv
// ----------------------------------------------------------------------------
// gmps_in_if / gmps_out_if
// Valid/ready channels for cell costs and path results.
// ----------------------------------------------------------------------------
interface gmps_in_if
  import gmps_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_cost;

  modport source (output valid, output cell_cost, input ready);
  modport sink (input valid, input cell_cost, output ready);
endinterface

interface gmps_out_if
  import gmps_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] total_cost;
  logic              start_outside;

  modport source (output valid, output total_cost, output start_outside, input ready);
  modport sink (input valid, input total_cost, input start_outside, output ready);
endinterface

### hdl/gmps_ram.sv
// ----------------------------------------------------------------------------
// gmps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/gmps_front.sv
// ----------------------------------------------------------------------------
// gmps_front
// Holds the configuration and the grid position, and tags each cell.
// ----------------------------------------------------------------------------
module gmps_front
  import gmps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gmps_in_if.sink               in_chan,
  input  queue_stat_t           q_stat,
  output logic                  q_push,
  output cell_op_t              q_op
);

  logic [DIM_W-1:0]   row_count_r, row_count_nxt;
  logic [DIM_W-1:0]   column_count_r, column_count_nxt;
  logic [START_W-1:0] start_row_r, start_row_nxt;
  logic [START_W-1:0] start_column_r, start_column_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;

  logic [ROWS_W-1:0]  rows;
  logic [COLS_W-1:0]  cols;
  logic               outside;
  logic               row_end;
  logic               col_end;
  logic               accept;

  // Zero counts as one; anything above the buffer size saturates.
  always_comb begin
    if (row_count_r == '0) begin
      rows = ROWS_W'(1);
    end else if (int'(row_count_r) > MAX_ROWS) begin
      rows = ROWS_W'(MAX_ROWS);
    end else begin
      rows = ROWS_W'(row_count_r);
    end
    if (column_count_r == '0) begin
      cols = COLS_W'(1);
    end else if (int'(column_count_r) > MAX_COLUMNS) begin
      cols = COLS_W'(MAX_COLUMNS);
    end else begin
      cols = COLS_W'(column_count_r);
    end
  end

  assign outside = (int'(start_row_r) >= int'(rows)) || (int'(start_column_r) >= int'(cols));
  assign row_end = (int'(cur_row_r) == int'(rows) - 1);
  assign col_end = (int'(cur_col_r) == int'(cols) - 1);

  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && !q_stat.full;
  assign q_push        = accept;

  always_comb begin
    q_op.cost     = in_chan.cell_cost;
    q_op.col      = cur_col_r;
    q_op.active   = !outside && (int'(cur_row_r) >= int'(start_row_r))
                    && (int'(cur_col_r) >= int'(start_column_r));
    q_op.has_up   = int'(cur_row_r) > int'(start_row_r);
    q_op.has_left = int'(cur_col_r) > int'(start_column_r);
    q_op.last     = row_end && col_end;
    q_op.outside  = outside;
  end

  always_comb begin
    row_count_nxt    = row_count_r;
    column_count_nxt = column_count_r;
    start_row_nxt    = start_row_r;
    start_column_nxt = start_column_r;
    cur_row_nxt      = cur_row_r;
    cur_col_nxt      = cur_col_r;
    if (cfg_wr_en) begin
      // Any configuration write restarts the grid at its first cell.
      cur_row_nxt = '0;
      cur_col_nxt = '0;
      case (cfg_reg_t'(cfg_index))
        CFG_ROW_COUNT:    row_count_nxt    = cfg_data;
        CFG_COLUMN_COUNT: column_count_nxt = cfg_data;
        CFG_START_ROW:    start_row_nxt    = cfg_data[START_W-1:0];
        CFG_START_COLUMN: start_column_nxt = cfg_data[START_W-1:0];
        default:          row_count_nxt    = row_count_r;
      endcase
    end else if (accept) begin
      if (col_end) begin
        cur_col_nxt = '0;
        cur_row_nxt = row_end ? '0 : ROW_W'(cur_row_r + 1'b1);
      end else begin
        cur_col_nxt = COL_W'(cur_col_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= DIM_W'(1);
      column_count_r <= DIM_W'(1);
      start_row_r    <= '0;
      start_column_r <= '0;
      cur_row_r      <= '0;
      cur_col_r      <= '0;
    end else begin
      row_count_r    <= row_count_nxt;
      column_count_r <= column_count_nxt;
      start_row_r    <= start_row_nxt;
      start_column_r <= start_column_nxt;
      cur_row_r      <= cur_row_nxt;
      cur_col_r      <= cur_col_nxt;
    end
  end

endmodule

### hdl/gmps_queue.sv
// ----------------------------------------------------------------------------
// gmps_queue
// Short register queue of classified cells between the front and the back.
// ----------------------------------------------------------------------------
module gmps_queue
  import gmps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cell_op_t    push_op,
  input  logic        pop,
  output cell_op_t    head_op,
  output queue_stat_t stat
);

  cell_op_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (int'(count_r) == QUEUE_DEPTH);
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_op    = slot_r[rd_ptr_r];

  // Pointers wrap naturally since the depth is a power of two.
  always_comb begin
    wr_ptr_nxt = do_push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hdl/gmps_back.sv
// ----------------------------------------------------------------------------
// gmps_back
// Row buffer update: one buffer read, one add and one compare per cell.
// ----------------------------------------------------------------------------
module gmps_back
  import gmps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  queue_stat_t q_stat,
  input  cell_op_t    q_head,
  output logic        q_pop,
  gmps_out_if.source  out_chan
);

  cell_op_t          s1_op_r, s1_op_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_fwd_r, s1_fwd_nxt;
  logic [COST_W-1:0] s1_fwd_val_r, s1_fwd_val_nxt;
  logic [COST_W-1:0] left_r, left_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [COST_W-1:0] out_total_r, out_total_nxt;
  logic              out_outside_r, out_outside_nxt;

  logic [COST_W-1:0] ram_q;
  logic [COST_W-1:0] up;
  logic [COST_W-1:0] prev;
  logic [COST_W-1:0] best;
  logic              s1_fire;
  logic              wr_en;

  gmps_ram #(
    .WIDTH (COST_W),
    .DEPTH (MAX_COLUMNS)
  ) u_row_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_op_r.col),
    .wr_data (best),
    .rd_en   (q_pop),
    .rd_addr (q_head.col),
    .rd_data (ram_q)
  );

  // A write to the same column in the cycle of the read is forwarded.
  assign up = s1_fwd_r ? s1_fwd_val_r : ram_q;

  always_comb begin
    if (s1_op_r.has_up && s1_op_r.has_left) begin
      prev = (up < left_r) ? up : left_r;
    end else if (s1_op_r.has_up) begin
      prev = up;
    end else if (s1_op_r.has_left) begin
      prev = left_r;
    end else begin
      prev = '0;
    end
  end

  assign best    = COST_W'(s1_op_r.cost) + prev;
  assign s1_fire = s1_valid_r && !(s1_op_r.last && out_valid_r && !out_chan.ready);
  assign wr_en   = s1_fire && s1_op_r.active;
  assign q_pop   = !q_stat.empty && (!s1_valid_r || s1_fire);

  always_comb begin
    s1_op_nxt       = s1_op_r;
    s1_valid_nxt    = s1_valid_r;
    s1_fwd_nxt      = s1_fwd_r;
    s1_fwd_val_nxt  = s1_fwd_val_r;
    left_nxt        = left_r;
    out_valid_nxt   = out_valid_r;
    out_total_nxt   = out_total_r;
    out_outside_nxt = out_outside_r;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
      if (s1_op_r.active) begin
        left_nxt = best;
      end
      if (s1_op_r.last) begin
        left_nxt        = '0;
        out_valid_nxt   = 1'b1;
        out_total_nxt   = s1_op_r.outside ? '0 : best;
        out_outside_nxt = s1_op_r.outside;
      end
    end

    if (q_pop) begin
      s1_valid_nxt   = 1'b1;
      s1_op_nxt      = q_head;
      s1_fwd_nxt     = wr_en && (s1_op_r.col == q_head.col);
      s1_fwd_val_nxt = best;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r       <= s1_op_nxt;
    s1_fwd_r      <= s1_fwd_nxt;
    s1_fwd_val_r  <= s1_fwd_val_nxt;
    out_total_r   <= out_total_nxt;
    out_outside_r <= out_outside_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.total_cost    = out_total_r;
  assign out_chan.start_outside = out_outside_r;

endmodule

### hdl/grid_min_path_sum.sv
// Throughput: one cell request per cycle, sustained, while results are taken.
// The last cell's result passes a queue slot, the stage register and the output register.
// The rate is set by the single row buffer RAM: one read and one write per cell.
// Reset (rst_n, synchronous, active low) restores the configuration to a 1x1 grid
// starting at (0,0), returns the position to the first cell and empties the queue
// and pipeline; the row buffer is not cleared, since every entry read is written earlier.
// ----------------------------------------------------------------------------
// grid_min_path_sum
// Streaming minimum path sum over a grid with down and right moves only.
// ----------------------------------------------------------------------------
module grid_min_path_sum
  import gmps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gmps_in_if.sink               in_chan,
  gmps_out_if.source            out_chan
);

  // The front keeps the configuration and the grid position. Every accepted
  // cell request is tagged with its column, whether it lies inside the
  // rectangle from the start cell to the goal, which neighbors count, and
  // whether it closes the grid.
  queue_stat_t q_stat;
  logic        q_push;
  logic        q_pop;
  cell_op_t    q_push_op;
  cell_op_t    q_head;

  gmps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_op      (q_push_op)
  );

  // The queue decouples the two sides: the front keeps taking cells, until the
  // queue is full, while a finished result waits on the output register.
  gmps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .pop     (q_pop),
    .head_op (q_head),
    .stat    (q_stat)
  );

  // The back reads the best cost above from the row buffer when it pops a
  // cell, then adds the cell cost to the smaller neighbor, writes the buffer
  // back and updates the running best cost to the left. A write and a read of
  // the same column in one cycle, as with a single-column grid, is forwarded.
  // At the last cell it loads the output register with the total or the flag
  // for a start cell outside the grid.
  gmps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

### verif/gmps_path_checker.sv
// ----------------------------------------------------------------------------
// gmps_path_checker
// Watches the configuration port and both channels of grid_min_path_sum. It
// keeps its own row buffer and position, predicts the result of every
// grid and compares each result request field by field.
// ----------------------------------------------------------------------------
module gmps_path_checker
  import gmps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gmps_in_if                    in_mon,
  gmps_out_if                   out_mon,
  output int unsigned           error_count,
  output int unsigned           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COST_W-1:0] total_cost;
    logic              start_outside;
  } path_result_t;

  path_result_t      expected_paths[$];

  // Mirror of the block's state and registers.
  logic [COST_W-1:0] best_above [MAX_COLUMNS];
  logic [COST_W-1:0] best_left;
  int unsigned       pos_row;
  int unsigned       pos_col;
  logic [DIM_W-1:0]  rows_reg;
  logic [DIM_W-1:0]  cols_reg;
  logic [START_W-1:0] start_row_reg;
  logic [START_W-1:0] start_col_reg;

  // A dimension of zero means one; anything past the buffer size saturates.
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v,
                                            input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  task automatic take_cell(input logic [CELL_W-1:0] cost);
    int unsigned       rows;
    int unsigned       cols;
    int unsigned       r;
    int unsigned       c;
    logic              outside;
    logic              last;
    logic              has_up;
    logic              has_left;
    logic [COST_W-1:0] prev;
    logic [COST_W-1:0] best;
    path_result_t      res;
    rows    = clamp_dim(rows_reg, MAX_ROWS);
    cols    = clamp_dim(cols_reg, MAX_COLUMNS);
    r       = pos_row;
    c       = pos_col;
    outside = (start_row_reg >= rows) || (start_col_reg >= cols);
    best    = '0;
    if (!outside && r >= start_row_reg && c >= start_col_reg) begin
      has_up   = r > start_row_reg;
      has_left = c > start_col_reg;
      prev     = '0;
      if (has_up && has_left) begin
        prev = (best_above[c] < best_left) ? best_above[c] : best_left;
      end else if (has_up) begin
        prev = best_above[c];
      end else if (has_left) begin
        prev = best_left;
      end
      best          = prev + COST_W'(cost);
      best_above[c] = best;
      best_left     = best;
    end
    last = (r == rows - 1) && (c == cols - 1);
    if (c + 1 >= cols) begin
      c = 0;
      r = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
    pos_row = r;
    pos_col = c;
    if (last) begin
      best_left         = '0;
      res.start_outside = outside;
      res.total_cost    = outside ? '0 : best;
      expected_paths.push_back(res);
    end
  endtask

  task automatic compare_path(input logic [COST_W-1:0] total, input logic outside);
    path_result_t want;
    if (expected_paths.size() == 0) begin
      $error("unexpected result: total_cost %0d, start_outside %0d", total, outside);
      error_count++;
    end else begin
      want = expected_paths.pop_front();
      if (total !== want.total_cost) begin
        $error("total_cost mismatch: expected %0d, actual %0d", want.total_cost, total);
        error_count++;
      end
      if (outside !== want.start_outside) begin
        $error("start_outside mismatch: expected %0d, actual %0d",
               want.start_outside, outside);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (best_above[i]) best_above[i] = '0;
      best_left     = '0;
      pos_row       = 0;
      pos_col       = 0;
      rows_reg      = DIM_W'(1);
      cols_reg      = DIM_W'(1);
      start_row_reg = '0;
      start_col_reg = '0;
      expected_paths.delete();
    end else begin
      // Any register write starts a fresh grid.
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ROW_COUNT:    rows_reg      = cfg_data;
          CFG_COLUMN_COUNT: cols_reg      = cfg_data;
          CFG_START_ROW:    start_row_reg = cfg_data[START_W-1:0];
          CFG_START_COLUMN: start_col_reg = cfg_data[START_W-1:0];
          default: ;
        endcase
        pos_row   = 0;
        pos_col   = 0;
        best_left = '0;
      end
      if (in_mon.valid && in_mon.ready) take_cell(in_mon.cell_cost);
      if (out_mon.valid && out_mon.ready) compare_path(out_mon.total_cost,
                                                       out_mon.start_outside);
    end
    outstanding = expected_paths.size();
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for grid_min_path_sum. Directed grids cover the
// register and cost extremes, a start outside the grid, a start on the goal
// and a restart in the middle of a grid; random grids of mostly small sizes
// follow, with bursty cell requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_top
  import gmps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Number of random cell requests to aim for once the directed part is done.
  // The directed grids send a little over 800 requests, so the whole run
  // comes to roughly 1050.
  localparam int unsigned RANDOM_CELLS  = 240;
  // The result trails the last cell through the queue and the back's registers;
  // SETTLE_CYCLES and END_CYCLES allow for it before the registers are touched or the verdict is given.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES    = 20;

  typedef enum int unsigned {
    COST_RANDOM,
    COST_MAX,
    COST_ZERO,
    COST_EXTREME,
    COST_LOW
  } cost_mode_e;

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_RANDOM,
    READY_DUTY
  } ready_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           error_count;
  int unsigned           outstanding;
  int unsigned           burst_left;

  gmps_in_if  in_chan ();
  gmps_out_if out_chan ();

  grid_min_path_sum dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // The checker sits beside the block and only listens; it reports back how
  // many results are still owed and how many mismatches it has seen.
  gmps_path_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or a result never shows up.
  initial begin
    #1ms;
    $display("status: fail");
    $finish;
  end

  // The result receiver moves between three behaviors: always ready, a random
  // draw each cycle that is ready seven times in ten, and a fixed duty cycle
  // that produces stalls. Each behavior lasts a random number of cycles.
  initial begin : result_receiver
    ready_mode_e mode;
    int unsigned span;
    int unsigned period;
    int unsigned duty;
    out_chan.ready = 1'b0;
    forever begin
      mode   = ready_mode_e'($urandom_range(0, 2));
      span   = $urandom_range(32, 200);
      period = $urandom_range(2, 16);
      duty   = $urandom_range(1, period - 1);
      for (int unsigned phase = 0; phase < span; phase++) begin
        @(negedge clk);
        case (mode)
          READY_ALWAYS: out_chan.ready <= 1'b1;
          READY_RANDOM: out_chan.ready <= ($urandom_range(0, 9) < 7);
          default:      out_chan.ready <= ((phase % period) < duty);
        endcase
      end
    end
  end

  // Number of rows or columns the block actually uses for a register value.
  function automatic int unsigned dim_in_use(input int unsigned v, input int unsigned limit);
    if (v == 0) return 1;
    return (v > limit) ? limit : v;
  endfunction

  function automatic logic [CELL_W-1:0] pick_cost(input cost_mode_e mode);
    case (mode)
      COST_MAX:     return '1;
      COST_ZERO:    return '0;
      COST_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      COST_LOW:     return CELL_W'($urandom_range(0, 3));
      default:      return CELL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Writes all four registers, one per cycle, then drops the write enable.
  // Called at a falling edge with the block idle; returns at a falling edge.
  task automatic configure(input int unsigned rows, input int unsigned cols,
                           input int unsigned srow, input int unsigned scol);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= CFG_DATA_W'(rows);
    @(negedge clk);
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_data  <= CFG_DATA_W'(cols);
    @(negedge clk);
    cfg_index <= CFG_START_ROW;
    cfg_data  <= CFG_DATA_W'(srow);
    @(negedge clk);
    cfg_index <= CFG_START_COLUMN;
    cfg_data  <= CFG_DATA_W'(scol);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Presents one cell request and holds it until the block takes it. The
  // sender runs in bursts; when a burst is used up a random gap, sometimes
  // none at all, comes before the next one.
  task automatic send_cell(input logic [CELL_W-1:0] cost);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_chan.valid     <= 1'b1;
    in_chan.cell_cost <= cost;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_grid(input int unsigned count, input cost_mode_e mode);
    for (int unsigned i = 0; i < count; i++) send_cell(pick_cost(mode));
  endtask

  // Stops the sender, waits for every owed result, then lets the pipeline
  // empty of cells that produce no result before the registers change.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned rows_cfg;
    int unsigned cols_cfg;
    int unsigned srow;
    int unsigned scol;
    int unsigned cells;
    int unsigned partial;
    int unsigned shape;
    int unsigned random_cells;

    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = CFG_ROW_COUNT;
    cfg_data          = '0;
    in_chan.valid     = 1'b0;
    in_chan.cell_cost = '0;
    burst_left        = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Out of reset the grid is a single cell, so every request is a whole
    // grid and yields its own cost.
    send_cell(8'h00);
    send_cell(8'hFF);
    send_cell(8'hAA);
    send_cell(8'h55);
    wait_idle();

    // Zero dimensions count as one.
    configure(0, 0, 0, 0);
    send_cell(8'hFF);
    wait_idle();

    // Full path from the top-left corner with every cost at its maximum.
    configure(2, 3, 0, 0);
    send_grid(6, COST_MAX);
    wait_idle();

    // Start in the middle: cells above and left of it must be ignored.
    configure(3, 3, 1, 1);
    send_grid(9, COST_RANDOM);
    wait_idle();

    // Start row beyond the grid, then start column beyond the grid.
    configure(2, 2, 2, 0);
    send_grid(4, COST_RANDOM);
    wait_idle();
    configure(2, 2, 0, 2);
    send_grid(4, COST_RANDOM);
    wait_idle();

    // Start on the goal cell: the total is the goal's own cost.
    configure(2, 2, 1, 1);
    send_grid(4, COST_RANDOM);
    wait_idle();

    // Abandon a grid halfway; the register writes must restart it.
    configure(3, 3, 0, 0);
    send_grid(4, COST_MAX);
    wait_idle();
    configure(3, 3, 0, 0);
    send_grid(9, COST_RANDOM);
    wait_idle();

    // Widest grid, columns saturated from the largest register value, all
    // costs at maximum so the total needs the top bit of the result.
    configure(3, 511, 0, 0);
    send_grid(3 * MAX_COLUMNS, COST_MAX);
    wait_idle();

    // Random grids. Most are small so results come often; a few stretch a
    // dimension to its saturated maximum. Roughly one start in seven is
    // anywhere in the 8-bit range, which usually lands outside the grid.
    // Some grids repeat without a register write, and now and then a grid
    // is cut short so the next configuration restarts it.
    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      shape = $urandom_range(0, 99);
      if (shape < 2) begin
        rows_cfg = $urandom_range(MAX_ROWS, 511);
        cols_cfg = $urandom_range(0, 1);
      end else if (shape < 4) begin
        rows_cfg = $urandom_range(0, 1);
        cols_cfg = $urandom_range(MAX_COLUMNS, 511);
      end else if (shape < 12) begin
        rows_cfg = $urandom_range(0, 16);
        cols_cfg = $urandom_range(0, 16);
      end else begin
        rows_cfg = $urandom_range(0, 6);
        cols_cfg = $urandom_range(0, 6);
      end
      if ($urandom_range(0, 99) < 15) begin
        srow = $urandom_range(0, 255);
        scol = $urandom_range(0, 255);
      end else begin
        srow = $urandom_range(0, dim_in_use(rows_cfg, MAX_ROWS) - 1);
        scol = $urandom_range(0, dim_in_use(cols_cfg, MAX_COLUMNS) - 1);
      end
      // The start registers are eight bits wide; the spare data bit is
      // toggled too, and the block has to drop it.
      srow |= $urandom_range(0, 1) << START_W;
      scol |= $urandom_range(0, 1) << START_W;
      configure(rows_cfg, cols_cfg, srow, scol);

      cells = dim_in_use(rows_cfg, MAX_ROWS) * dim_in_use(cols_cfg, MAX_COLUMNS);
      repeat ($urandom_range(1, 3)) begin
        send_grid(cells, cost_mode_e'($urandom_range(0, 4)));
        random_cells += cells;
      end
      if (cells > 1 && $urandom_range(0, 9) == 0) begin
        partial = $urandom_range(1, cells - 1);
        send_grid(partial, COST_RANDOM);
        random_cells += partial;
      end
      wait_idle();
    end

    // Everything has been sent; wait out the last results and a short tail
    // in which any stray result would still be caught.
    in_chan.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
hdl/gmps_pkg.sv
hdl/gmps_if.sv
hdl/gmps_ram.sv
hdl/gmps_front.sv
hdl/gmps_queue.sv
hdl/gmps_back.sv
hdl/grid_min_path_sum.sv
verif/gmps_path_checker.sv
verif/tb_top.sv
